@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg: shared constants and types for the double-ended queue
// Request and status codes, sizing of the cell row and the tail OR tree.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 1024;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int GROUP   = 32;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // one-cycle command broadcast to every cell; at most one bit set
    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } cell_ctrl_t;

endpackage

@@ rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell: one slot of the queue row
// Holds one word and an occupied flag; shifts with its neighbours on front
// operations, loads or drops at the tail on back operations.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  deq_pkg::cell_ctrl_t              ctrl,
    input  logic signed [deq_pkg::WORD_W-1:0] push_value,
    input  logic signed [deq_pkg::WORD_W-1:0] left_data,
    input  logic                             left_occ,
    input  logic signed [deq_pkg::WORD_W-1:0] right_data,
    input  logic                             right_occ,
    output logic signed [deq_pkg::WORD_W-1:0] data,
    output logic                             occ,
    output logic signed [deq_pkg::WORD_W-1:0] tail_word
);

    logic signed [deq_pkg::WORD_W-1:0] data_reg;
    logic signed [deq_pkg::WORD_W-1:0] data_next;
    logic                              occ_reg;
    logic                              occ_next;
    logic                              is_last;

    assign is_last = occ_reg && !right_occ;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.add_front)
        begin
            data_next = left_data;
            occ_next  = left_occ;
        end
        else if (ctrl.take_front)
        begin
            data_next = right_data;
            occ_next  = right_occ;
        end
        else if (ctrl.add_back)
        begin
            // first free slot after the last occupied one
            if (!occ_reg && left_occ)
            begin
                data_next = push_value;
                occ_next  = 1'b1;
            end
        end
        else if (ctrl.take_back)
        begin
            if (is_last)
                occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign occ       = occ_reg;
    assign tail_word = is_last ? data_reg : '0;

endmodule

@@ rtl/deq_group.sv @@
// ----------------------------------------------------------------------------
// deq_group: first level of the tail-word OR tree
// Registers the OR of one group of cell tail words.
// ----------------------------------------------------------------------------
module deq_group (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [deq_pkg::WORD_W-1:0] words [deq_pkg::GROUP],
    output logic signed [deq_pkg::WORD_W-1:0] group_word
);

    logic signed [deq_pkg::WORD_W-1:0] group_reg;
    logic signed [deq_pkg::WORD_W-1:0] group_next;

    // at most one cell in the whole row is the tail, so OR acts as a select
    always_comb
    begin
        group_next = '0;
        for (int j = 0; j < deq_pkg::GROUP; j++)
            group_next = group_next | words[j];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            group_reg <= group_next;
    end

    assign group_word = group_reg;

endmodule

@@ rtl/double_ended_queue_top.sv @@
// A new request item is taken only in ST_IDLE, so each item passes through
//   the cell update, the registered group ORs of the tail words and the
//   output register before the next one is accepted.
// The next item is taken while a finished result still waits in the output
//   register; a new result is only loaded once that register is free.
// Reset (rst_n, async, active low) empties the queue; cell data is not reset.
// ----------------------------------------------------------------------------
// double_ended_queue_top: double-ended queue built as a row of cells
// Front sits in cell 0; front operations shift the whole row one place,
// back operations load the cell just past the occupied run or drop its last cell.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic         clk,
    input  logic         rst_n,
    // request side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [2:0] req_type, [34:3] push_value, [39:35] zero
    // result side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata    // [1:0] status, [33:2] popped_value,
                                    // [44:34] entry_count, [45] is_empty,
                                    // [77:46] front_value, [109:78] back_value,
                                    // [111:110] zero
);

    localparam int WORD_W  = deq_pkg::WORD_W;
    localparam int CNT_W   = deq_pkg::CNT_W;
    localparam int DEPTH   = deq_pkg::DEPTH;
    localparam int GROUP   = deq_pkg::GROUP;
    localparam int NGROUPS = deq_pkg::NGROUPS;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;  // cells settled, group ORs register
    localparam logic [1:0] ST_FINISH = 2'd2;  // final OR, result into output reg

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // request fields
    logic [deq_pkg::REQ_W-1:0] req_type;
    logic signed [WORD_W-1:0]  push_value;
    logic                      accept;

    assign req_type   = s_tdata[2:0];
    assign push_value = s_tdata[34:3];
    assign accept     = s_tvalid && s_tready;

    // queue bookkeeping
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [WORD_W-1:0]  back_reg;
    logic signed [WORD_W-1:0]  back_next;
    logic [deq_pkg::STAT_W-1:0] status_reg;
    logic [deq_pkg::STAT_W-1:0] status_next;
    logic signed [WORD_W-1:0]  popped_reg;
    logic signed [WORD_W-1:0]  popped_next;

    deq_pkg::cell_ctrl_t       ctrl;

    // cell row
    logic signed [WORD_W-1:0]  cell_data [DEPTH];
    logic                      cell_occ  [DEPTH];
    logic signed [WORD_W-1:0]  cell_tail [DEPTH];

    logic                      is_full;
    logic                      is_empty_now;

    assign is_full      = (count_reg == FULL_COUNT);
    assign is_empty_now = (count_reg == '0);

    // ------------------------------------------------------------------
    // Request decode: commands reach the cells only when they are legal,
    // so a rejected item leaves the row untouched.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        if (accept)
        begin
            status_next = deq_pkg::STAT_OK;
            popped_next = '0;
            case (req_type)
                deq_pkg::REQ_PUSH_FRONT,
                deq_pkg::REQ_PUSH_BACK:
                begin
                    if (is_full)
                        status_next = deq_pkg::STAT_FULL;
                    else
                    begin
                        ctrl.add_front = (req_type == deq_pkg::REQ_PUSH_FRONT);
                        ctrl.add_back  = (req_type == deq_pkg::REQ_PUSH_BACK);
                        count_next     = count_reg + 1'b1;
                    end
                end
                deq_pkg::REQ_POP_FRONT:
                begin
                    if (is_empty_now)
                        status_next = deq_pkg::STAT_EMPTY;
                    else
                    begin
                        ctrl.take_front = 1'b1;
                        popped_next     = cell_data[0];
                        count_next      = count_reg - 1'b1;
                    end
                end
                deq_pkg::REQ_POP_BACK:
                begin
                    if (is_empty_now)
                        status_next = deq_pkg::STAT_EMPTY;
                    else
                    begin
                        // back_reg holds the current tail word whenever an item is accepted
                        ctrl.take_back = 1'b1;
                        popped_next    = back_reg;
                        count_next     = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    // query, and the unused codes that behave as query
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell row: each cell sees its neighbours; the ends are tied off so
    // cell 0 takes the pushed word and the last cell pulls in an empty slot.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [WORD_W-1:0] l_data;
            logic                     l_occ;
            logic signed [WORD_W-1:0] r_data;
            logic                     r_occ;

            if (gi == 0)
            begin : g_head
                assign l_data = push_value;
                assign l_occ  = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_data = cell_data[gi-1];
                assign l_occ  = cell_occ[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign r_data = '0;
                assign r_occ  = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data = cell_data[gi+1];
                assign r_occ  = cell_occ[gi+1];
            end

            deq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .push_value (push_value),
                .left_data  (l_data),
                .left_occ   (l_occ),
                .right_data (r_data),
                .right_occ  (r_occ),
                .data       (cell_data[gi]),
                .occ        (cell_occ[gi]),
                .tail_word  (cell_tail[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Tail word OR tree: groups registered in ST_GATHER, final OR used
    // in ST_FINISH. Only the tail cell drives a non-zero word.
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] group_in  [NGROUPS][GROUP];
    logic signed [WORD_W-1:0] group_out [NGROUPS];
    logic signed [WORD_W-1:0] tail_or;
    logic                     group_load;

    assign group_load = (state_reg == ST_GATHER);

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < DEPTH)
                    group_in[g][j] = cell_tail[g * GROUP + j];
                else
                    group_in[g][j] = '0;
            end
        end
    end

    generate
        for (gi = 0; gi < NGROUPS; gi++)
        begin : g_group
            deq_group u_group (
                .clk        (clk),
                .load       (group_load),
                .words      (group_in[gi]),
                .group_word (group_out[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tail_or = '0;
        for (int g = 0; g < NGROUPS; g++)
            tail_or = tail_or | group_out[g];
    end

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [deq_pkg::STAT_W-1:0] o_status_reg;
    logic signed [WORD_W-1:0]  o_popped_reg;
    logic [CNT_W-1:0]          o_count_reg;
    logic                      o_empty_reg;
    logic signed [WORD_W-1:0]  o_front_reg;
    logic signed [WORD_W-1:0]  o_back_reg;
    logic                      out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_GATHER;
            end
            ST_GATHER:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    assign back_next = out_load ? tail_or : back_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            back_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
        if (out_load)
        begin
            o_status_reg <= status_reg;
            o_popped_reg <= popped_reg;
            o_count_reg  <= count_reg;
            o_empty_reg  <= is_empty_now;
            o_front_reg  <= cell_occ[0] ? cell_data[0] : '0;
            o_back_reg   <= tail_or;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, o_back_reg, o_front_reg, o_empty_reg,
                       o_count_reg, o_popped_reg, o_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == cell_occ[0])
        else $error("cell 0 occupancy disagrees with entry count");

    a_last_matches_full: assert property (@(posedge clk) disable iff (!rst_n)
        is_full == cell_occ[DEPTH-1])
        else $error("last cell occupancy disagrees with full count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_accept_starts_gather: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_GATHER))
        else $error("accepted item did not start the tail gather");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("result load did not raise m_tvalid");

endmodule
